FILE: rtl/assert_macros.svh
// Assertion helpers used by the sequencer (cvpz_seq).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, a, b)
`define ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

FILE: rtl/cvpz_pkg.sv
package cvpz_pkg;

  localparam int QW       = 48;  // Q4.44 bound width
  localparam int AW       = 64;  // internal datapath width
  localparam int PIXW     = 10;
  localparam int OPW      = 3;
  localparam int PCW      = 5;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 64;
  localparam int DIV_BITS = 8;   // quotient bits per divider cycle

  localparam int PAN_DIV      = 20;
  localparam int PAN_BIAS     = 10;
  localparam int ZOOM_IN_DIV  = 4;
  localparam int ZOOM_OUT_DIV = 6;

  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_MIN_RE,
    REG_MAX_RE,
    REG_MIN_IM,
    REG_MAX_IM
  } reg_idx_t;

  // Reset values of the home registers, indexed by reg_idx_t
  localparam logic [3:0][QW-1:0] HOME_RST = {
    48'h1800_0000_0000,  // max_im  1.5
    48'hE800_0000_0000,  // min_im -1.5
    48'h1000_0000_0000,  // max_re  1.0
    48'hE000_0000_0000   // min_re -2.0
  };

  typedef enum logic [OPW-1:0] {
    OP_LEFT  = 3'd0,
    OP_RIGHT = 3'd1,
    OP_UP    = 3'd2,
    OP_DOWN  = 3'd3,
    OP_ZIN   = 3'd4,
    OP_ZOUT  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ALU_NONE,
    ALU_SPAN,
    ALU_ABS10,
    ALU_MULPIX,
    ALU_SUBPT,
    ALU_MUL5
  } alu_t;

  typedef enum logic [1:0] {
    WB_NONE,
    WB_PT,
    WB_ZOOM,
    WB_PAN
  } wb_t;

  typedef enum logic [1:0] {
    DV_VIEW,
    DV_PAN,
    DV_ZOOM
  } dsel_t;

  typedef enum logic {
    B_LO,
    B_HI
  } bsel_t;

  typedef enum logic [2:0] {
    SQ_NEXT,
    SQ_WAIT,
    SQ_JUMP,
    SQ_LOOP,
    SQ_DONE
  } seq_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    alu_t           alu;
    wb_t            wb;
    logic           div_start;
    dsel_t          dsel;
    bsel_t          bsel;
    seq_t           seq;
    logic [PCW-1:0] target;
  } uword_t;

  typedef struct packed {
    uword_t w;
    logic   load;
    logic   emit;
  } ctl_t;

  typedef struct packed {
    logic div_busy;
    logic axis_im;
  } stat_t;

  typedef struct packed {
    logic          we;
    reg_idx_t      idx;
    logic [QW-1:0] data;
  } cfg_t;

  localparam uword_t UW_NOP = '{
    alu: ALU_NONE, wb: WB_NONE, div_start: 1'b0, dsel: DV_PAN,
    bsel: B_LO, seq: SQ_NEXT, target: {PCW{1'b0}}
  };

  localparam logic [PCW-1:0] PC_PAN  = 5'd0;
  localparam logic [PCW-1:0] PC_ZOOM = 5'd6;
  localparam logic [PCW-1:0] PC_DONE = 5'd21;

  function automatic logic [PCW-1:0] entry(input logic [OPW-1:0] op);
    logic [PCW-1:0] e;
    case (op) inside
      [OP_LEFT:OP_DOWN]: e = PC_PAN;
      OP_ZIN, OP_ZOUT:   e = PC_ZOOM;
      default:           e = PC_DONE;
    endcase
    return e;
  endfunction

  // Microprogram. Zoom runs the real axis, then loops once for the imaginary axis.
  function automatic uword_t ucode(input logic [PCW-1:0] pc);
    uword_t w;
    w = UW_NOP;
    case (pc)
      // pan
      5'd0:  w.alu = ALU_SPAN;
      5'd1:  w.alu = ALU_ABS10;
      5'd2:  begin
        w.div_start = 1'b1;
        w.dsel      = DV_PAN;
      end
      5'd3:  w.seq = SQ_WAIT;
      5'd4:  begin
        w.wb   = WB_PAN;
        w.bsel = B_LO;
      end
      5'd5:  begin
        w.wb     = WB_PAN;
        w.bsel   = B_HI;
        w.seq    = SQ_JUMP;
        w.target = PC_DONE;
      end
      // zoom: pointer point on the current axis
      5'd6:  w.alu = ALU_SPAN;
      5'd7:  w.alu = ALU_MULPIX;
      5'd8:  begin
        w.div_start = 1'b1;
        w.dsel      = DV_VIEW;
      end
      5'd9:  w.seq = SQ_WAIT;
      5'd10: w.wb = WB_PT;
      // lower bound
      5'd11: begin
        w.alu  = ALU_SUBPT;
        w.bsel = B_LO;
      end
      5'd12: w.alu = ALU_MUL5;
      5'd13: begin
        w.div_start = 1'b1;
        w.dsel      = DV_ZOOM;
      end
      5'd14: w.seq = SQ_WAIT;
      5'd15: begin
        w.wb   = WB_ZOOM;
        w.bsel = B_LO;
      end
      // upper bound
      5'd16: begin
        w.alu  = ALU_SUBPT;
        w.bsel = B_HI;
      end
      5'd17: w.alu = ALU_MUL5;
      5'd18: begin
        w.div_start = 1'b1;
        w.dsel      = DV_ZOOM;
      end
      5'd19: w.seq = SQ_WAIT;
      5'd20: begin
        w.wb     = WB_ZOOM;
        w.bsel   = B_HI;
        w.seq    = SQ_LOOP;
        w.target = PC_ZOOM;
      end
      5'd21: w.seq = SQ_DONE;
      default: w.seq = SQ_DONE;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/complex_viewport_pan_zoom.sv
// Complex-plane viewport: holds four Q4.44 bounds and updates them per event.
// Input channel (in_valid / in_stall, op, pix_x, pix_y): one transaction is one
// event; ops 0..3 pan by 1/20 of the axis span, 4 and 5 zoom about the pointer,
// 6 and 7 leave the bounds as they are.
// Output channel (out_valid / out_stall, out_min_re .. out_max_im): one
// transaction per event carrying the bounds after the update.
// APB port: home registers at 8*i; a write also loads the matching bound.
// From input acceptance, the microcode steps one shared divider that retires
// 8 quotient bits per cycle: one divide per pan, six per zoom, none for an
// unused op. The next event is taken the cycle after the result is
// registered.
// Reset puts all bounds and home registers at their home reset values and
// empties the output register.
// A stalled result holds in the output register while the next event is
// accepted and worked on; that event then waits on its last step until the
// output register is taken.
module complex_viewport_pan_zoom #(
  parameter int VIEW_WIDTH  = 1024,
  parameter int VIEW_HEIGHT = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [cvpz_pkg::PADDR_W-1:0]  paddr,
  input  logic        [cvpz_pkg::PDATA_W-1:0]  pwdata,
  output logic        [cvpz_pkg::PDATA_W-1:0]  prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic        [cvpz_pkg::OPW-1:0]      op,
  input  logic        [cvpz_pkg::PIXW-1:0]     pix_x,
  input  logic        [cvpz_pkg::PIXW-1:0]     pix_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cvpz_pkg::QW-1:0]       out_min_re,
  output logic signed [cvpz_pkg::QW-1:0]       out_max_re,
  output logic signed [cvpz_pkg::QW-1:0]       out_min_im,
  output logic signed [cvpz_pkg::QW-1:0]       out_max_im
);

  localparam int QW = cvpz_pkg::QW;

  cvpz_pkg::cfg_t  cfg;
  cvpz_pkg::ctl_t  ctl;
  cvpz_pkg::stat_t stat;
  logic [QW-1:0]   home [4];
  logic [QW-1:0]   rd_home;

  assign pready   = 1'b1;
  assign cfg.we   = psel && penable && pwrite;
  assign cfg.idx  = cvpz_pkg::reg_idx_t'(paddr[cvpz_pkg::PADDR_W-1:3]);
  assign cfg.data = pwdata[QW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        home[i] <= cvpz_pkg::HOME_RST[i];
      end
    end else if (cfg.we) begin
      home[cfg.idx] <= cfg.data;
    end
  end

  assign rd_home = home[paddr[cvpz_pkg::PADDR_W-1:3]];
  assign prdata  = {{(cvpz_pkg::PDATA_W-QW){rd_home[QW-1]}}, rd_home};

  cvpz_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  cvpz_dp #(
    .VIEW_WIDTH (VIEW_WIDTH),
    .VIEW_HEIGHT(VIEW_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cfg       (cfg),
    .op        (op),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .stat      (stat),
    .out_min_re(out_min_re),
    .out_max_re(out_max_re),
    .out_min_im(out_min_im),
    .out_max_im(out_max_im)
  );

endmodule

FILE: rtl/cvpz_div.sv
module cvpz_div #(
  parameter int DVW = 13
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [cvpz_pkg::AW-1:0]    num,
  input  logic        [DVW-1:0]             den,
  output logic                              busy,
  output logic signed [cvpz_pkg::AW-1:0]    quo
);

  localparam int AW    = cvpz_pkg::AW;
  localparam int STEPS = AW / cvpz_pkg::DIV_BITS;
  localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [AW-1:0]  sh;
  logic [AW-1:0]  sh_next;
  logic [DVW-1:0] rem;
  logic [DVW-1:0] rem_next;
  logic [DVW-1:0] den_q;
  logic [CW-1:0]  cnt;
  logic           neg;

  logic [AW-1:0]  s;
  logic [DVW-1:0] r;
  logic [DVW:0]   t;

  // Restoring long division, DIV_BITS quotient bits per cycle
  always_comb begin
    r = rem;
    s = sh;
    t = '0;
    for (int k = 0; k < cvpz_pkg::DIV_BITS; k++) begin
      t = {r, s[AW-1]};
      s = {s[AW-2:0], 1'b0};
      if (t >= {1'b0, den_q}) begin
        t    = t - {1'b0, den_q};
        s[0] = 1'b1;
      end
      r = t[DVW-1:0];
    end
    rem_next = r;
    sh_next  = s;
  end

  // floor(n/d) for negative n is ~floor(~n/d)
  assign quo = neg ? ~sh : sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (cnt == CW'(STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= num[AW-1];
      sh    <= num[AW-1] ? ~num : num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      sh  <= sh_next;
      rem <= rem_next;
    end
  end

endmodule

FILE: rtl/cvpz_dp.sv
module cvpz_dp #(
  parameter int VIEW_WIDTH  = 1024,
  parameter int VIEW_HEIGHT = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cvpz_pkg::ctl_t                       ctl,
  input  cvpz_pkg::cfg_t                       cfg,
  input  logic        [cvpz_pkg::OPW-1:0]      op,
  input  logic        [cvpz_pkg::PIXW-1:0]     pix_x,
  input  logic        [cvpz_pkg::PIXW-1:0]     pix_y,
  output cvpz_pkg::stat_t                      stat,
  output logic signed [cvpz_pkg::QW-1:0]       out_min_re,
  output logic signed [cvpz_pkg::QW-1:0]       out_max_re,
  output logic signed [cvpz_pkg::QW-1:0]       out_min_im,
  output logic signed [cvpz_pkg::QW-1:0]       out_max_im
);

  localparam int QW   = cvpz_pkg::QW;
  localparam int AW   = cvpz_pkg::AW;
  localparam int PIXW = cvpz_pkg::PIXW;
  localparam int MW   = QW + PIXW + 2;
  localparam int VMAX = (VIEW_WIDTH > VIEW_HEIGHT) ? VIEW_WIDTH : VIEW_HEIGHT;
  localparam int DMAX = (VMAX > cvpz_pkg::PAN_DIV) ? VMAX : cvpz_pkg::PAN_DIV;
  localparam int DVW  = $clog2(DMAX + 1);

  cvpz_pkg::uword_t w;

  logic signed [QW-1:0] lo_re, hi_re, lo_im, hi_im;
  logic signed [AW-1:0] acc, acc_next;
  logic signed [AW-1:0] pt;
  logic [cvpz_pkg::OPW-1:0] op_q;
  logic [PIXW-1:0] px_q, py_q;
  logic            axis;

  logic signed [QW-1:0] lo_ax, hi_ax, bnd_sel;
  logic signed [AW-1:0] lo_ext, hi_ext, bnd_ext;
  logic [AW-1:0]        abs_opa;
  logic [PIXW-1:0]      pix;
  logic signed [MW-1:0] prod;
  logic signed [AW-1:0] wb_x, wb_sum;
  logic                 wb_sub;
  logic signed [QW-1:0] wb_sat;
  logic                 pan_add;
  logic [DVW-1:0]       den;
  logic                 div_busy;
  logic signed [AW-1:0] q;
  cvpz_pkg::reg_idx_t   dest;

  assign w = ctl.w;

  assign lo_ax   = axis ? lo_im : lo_re;
  assign hi_ax   = axis ? hi_im : hi_re;
  assign bnd_sel = (w.bsel == cvpz_pkg::B_HI) ? hi_ax : lo_ax;
  assign lo_ext  = {{(AW-QW){lo_ax[QW-1]}}, lo_ax};
  assign hi_ext  = {{(AW-QW){hi_ax[QW-1]}}, hi_ax};
  assign bnd_ext = {{(AW-QW){bnd_sel[QW-1]}}, bnd_sel};
  assign pix     = axis ? py_q : px_q;
  assign pan_add = (op_q == cvpz_pkg::OP_RIGHT) || (op_q == cvpz_pkg::OP_UP);
  assign dest    = cvpz_pkg::reg_idx_t'({axis, w.bsel});

  assign stat.div_busy = div_busy;
  assign stat.axis_im  = axis;

  always_comb begin
    abs_opa  = acc[AW-1] ? ~acc : acc;
    prod     = $signed(acc[QW:0]) * $signed({1'b0, pix});
    case (w.alu)
      cvpz_pkg::ALU_SPAN:   acc_next = hi_ext - lo_ext;
      // |acc| + bias with one adder: negative takes ~acc + bias + 1
      cvpz_pkg::ALU_ABS10:  acc_next = abs_opa + (acc[AW-1] ? AW'(cvpz_pkg::PAN_BIAS + 1)
                                                            : AW'(cvpz_pkg::PAN_BIAS));
      cvpz_pkg::ALU_MULPIX: acc_next = {{(AW-MW){prod[MW-1]}}, prod};
      cvpz_pkg::ALU_SUBPT:  acc_next = bnd_ext - pt;
      cvpz_pkg::ALU_MUL5:   acc_next = acc + {acc[AW-3:0], 2'b00};
      default:              acc_next = acc;
    endcase
  end

  always_comb begin
    case (w.wb)
      cvpz_pkg::WB_PT: begin
        wb_x   = axis ? hi_ext : lo_ext;
        wb_sub = axis;
      end
      cvpz_pkg::WB_PAN: begin
        wb_x   = bnd_ext;
        wb_sub = !pan_add;
      end
      default: begin
        wb_x   = pt;
        wb_sub = 1'b0;
      end
    endcase
    wb_sum = wb_x + (wb_sub ? ~q : q) + AW'(wb_sub);
    if ((&wb_sum[AW-1:QW-1]) || !(|wb_sum[AW-1:QW-1])) begin
      wb_sat = wb_sum[QW-1:0];
    end else begin
      wb_sat = wb_sum[AW-1] ? cvpz_pkg::Q_MIN : cvpz_pkg::Q_MAX;
    end
  end

  always_comb begin
    case (w.dsel)
      cvpz_pkg::DV_VIEW: den = axis ? DVW'(VIEW_HEIGHT) : DVW'(VIEW_WIDTH);
      cvpz_pkg::DV_ZOOM: den = (op_q == cvpz_pkg::OP_ZOUT) ? DVW'(cvpz_pkg::ZOOM_OUT_DIV)
                                                           : DVW'(cvpz_pkg::ZOOM_IN_DIV);
      default:           den = DVW'(cvpz_pkg::PAN_DIV);
    endcase
  end

  cvpz_div #(
    .DVW(DVW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(w.div_start),
    .num  (acc),
    .den  (den),
    .busy (div_busy),
    .quo  (q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_re <= cvpz_pkg::HOME_RST[cvpz_pkg::REG_MIN_RE];
      hi_re <= cvpz_pkg::HOME_RST[cvpz_pkg::REG_MAX_RE];
      lo_im <= cvpz_pkg::HOME_RST[cvpz_pkg::REG_MIN_IM];
      hi_im <= cvpz_pkg::HOME_RST[cvpz_pkg::REG_MAX_IM];
      axis  <= 1'b0;
    end else begin
      if (cfg.we) begin
        case (cfg.idx)
          cvpz_pkg::REG_MIN_RE: lo_re <= cfg.data;
          cvpz_pkg::REG_MAX_RE: hi_re <= cfg.data;
          cvpz_pkg::REG_MIN_IM: lo_im <= cfg.data;
          cvpz_pkg::REG_MAX_IM: hi_im <= cfg.data;
          default: ;
        endcase
      end
      if ((w.wb == cvpz_pkg::WB_ZOOM) || (w.wb == cvpz_pkg::WB_PAN)) begin
        case (dest)
          cvpz_pkg::REG_MIN_RE: lo_re <= wb_sat;
          cvpz_pkg::REG_MAX_RE: hi_re <= wb_sat;
          cvpz_pkg::REG_MIN_IM: lo_im <= wb_sat;
          cvpz_pkg::REG_MAX_IM: hi_im <= wb_sat;
          default: ;
        endcase
      end
      // pan codes carry the axis in bit 1; zoom codes start on the real axis
      if (ctl.load) begin
        axis <= op[1];
      end else if ((w.seq == cvpz_pkg::SQ_LOOP) && !axis) begin
        axis <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (w.wb == cvpz_pkg::WB_PT) begin
      pt <= wb_sum;
    end
    if (ctl.load) begin
      op_q <= op;
      px_q <= pix_x;
      py_q <= pix_y;
    end
    if (ctl.emit) begin
      out_min_re <= lo_re;
      out_max_re <= hi_re;
      out_min_im <= lo_im;
      out_max_im <= hi_im;
    end
  end

endmodule

FILE: rtl/cvpz_seq.sv
`include "assert_macros.svh"

module cvpz_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [cvpz_pkg::OPW-1:0]      op,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  cvpz_pkg::stat_t               stat,
  output cvpz_pkg::ctl_t                ctl
);

  localparam int PCW = cvpz_pkg::PCW;

  cvpz_pkg::state_t state, state_next;
  logic [PCW-1:0]   pc, pc_next;
  cvpz_pkg::uword_t w;

  assign w        = cvpz_pkg::ucode(pc);
  assign in_stall = (state != cvpz_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cvpz_pkg::ST_IDLE;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      if (ctl.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    ctl.w      = cvpz_pkg::UW_NOP;
    ctl.load   = 1'b0;
    ctl.emit   = 1'b0;
    case (state)
      cvpz_pkg::ST_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          pc_next    = cvpz_pkg::entry(op);
          state_next = cvpz_pkg::ST_RUN;
        end
      end
      cvpz_pkg::ST_RUN: begin
        ctl.w = w;
        case (w.seq)
          cvpz_pkg::SQ_NEXT: pc_next = pc + PCW'(1);
          cvpz_pkg::SQ_WAIT: begin
            if (!stat.div_busy) begin
              pc_next = pc + PCW'(1);
            end
          end
          cvpz_pkg::SQ_JUMP: pc_next = w.target;
          cvpz_pkg::SQ_LOOP: pc_next = stat.axis_im ? pc + PCW'(1) : w.target;
          cvpz_pkg::SQ_DONE: begin
            // hold until the output register is free
            if (!out_valid || !out_stall) begin
              ctl.emit   = 1'b1;
              state_next = cvpz_pkg::ST_IDLE;
            end
          end
          default: state_next = cvpz_pkg::ST_IDLE;
        endcase
      end
      default: state_next = cvpz_pkg::ST_IDLE;
    endcase
  end

  `ASSERT_NEXT(a_accept_runs, clk, rst, in_valid && !in_stall, in_stall)
  `ASSERT_NEXT(a_wait_holds, clk, rst, (state == cvpz_pkg::ST_RUN) && (w.seq == cvpz_pkg::SQ_WAIT) && stat.div_busy, $stable(pc))
  `ASSERT_IMPL(a_div_free, clk, rst, (state == cvpz_pkg::ST_RUN) && w.div_start, !stat.div_busy)
  `ASSERT_NEXT(a_emit_valid, clk, rst, ctl.emit, out_valid && !in_stall)

endmodule

FILE: dv/complex_viewport_pan_zoom_tb.sv
`timescale 1ns / 1ps

module complex_viewport_pan_zoom_tb;
  import cvpz_pkg::*;

  localparam int VIEW_W = 1024;
  localparam int VIEW_H = 1024;
  localparam longint SAT_HI = (64'sd1 <<< 47) - 1;
  localparam longint SAT_LO = -(64'sd1 <<< 47);
  localparam longint PAN_STEPS = 20;
  localparam longint PAN_ROUND = 10;
  localparam longint ZIN_DIV = 4;
  localparam longint ZOUT_DIV = 6;
  localparam logic [OPW-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OPW-1:0] OP_SPARE7 = 3'd7;
  localparam int PHASES = 6;
  localparam int EVENTS_PER_PHASE = 125;

  typedef logic signed [QW-1:0] q48_t;

  typedef struct packed {
    q48_t min_re;
    q48_t max_re;
    q48_t min_im;
    q48_t max_im;
  } view_t;

  class view_tracker;
    longint lo_re, hi_re, lo_im, hi_im;
    view_t expected_views[$];
    int mismatches;
    int n_checked;
    int n_pan;
    int n_zoom;
    int n_spare;
    int n_writes;

    function void restore_home();
      lo_re = longint'(q48_t'(HOME_RST[REG_MIN_RE]));
      hi_re = longint'(q48_t'(HOME_RST[REG_MAX_RE]));
      lo_im = longint'(q48_t'(HOME_RST[REG_MIN_IM]));
      hi_im = longint'(q48_t'(HOME_RST[REG_MAX_IM]));
    endfunction

    function longint clamp(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
    endfunction

    function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) < 0) q--;
      return q;
    endfunction

    function longint pan_shift(longint lo, longint hi);
      longint span;
      span = hi - lo;
      if (span < 0) span = -span;
      return (span + PAN_ROUND) / PAN_STEPS;
    endfunction

    function longint scale_about(longint pt, longint bound, longint div);
      return clamp(pt + floor_div((bound - pt) * 5, div));
    endfunction

    function void load_home(reg_idx_t idx, q48_t v);
      n_writes++;
      case (idx)
        REG_MIN_RE: lo_re = longint'(v);
        REG_MAX_RE: hi_re = longint'(v);
        REG_MIN_IM: lo_im = longint'(v);
        REG_MAX_IM: hi_im = longint'(v);
      endcase
    endfunction

    function void take_event(logic [OPW-1:0] code, logic [PIXW-1:0] x, logic [PIXW-1:0] y);
      longint shift, div, pt_re, pt_im;
      longint nlr, nhr, nli, nhi;
      view_t v;
      case (code)
        OP_LEFT, OP_RIGHT: begin
          shift = pan_shift(lo_re, hi_re);
          if (code == OP_RIGHT) begin
            lo_re = clamp(lo_re + shift);
            hi_re = clamp(hi_re + shift);
          end else begin
            lo_re = clamp(lo_re - shift);
            hi_re = clamp(hi_re - shift);
          end
          n_pan++;
        end
        OP_UP, OP_DOWN: begin
          shift = pan_shift(lo_im, hi_im);
          if (code == OP_UP) begin
            lo_im = clamp(lo_im + shift);
            hi_im = clamp(hi_im + shift);
          end else begin
            lo_im = clamp(lo_im - shift);
            hi_im = clamp(hi_im - shift);
          end
          n_pan++;
        end
        OP_ZIN, OP_ZOUT: begin
          div = (code == OP_ZIN) ? ZIN_DIV : ZOUT_DIV;
          // pointer point stays unsaturated; rows count down from the top bound
          pt_re = lo_re + floor_div(longint'(x) * (hi_re - lo_re), VIEW_W);
          pt_im = hi_im - floor_div(longint'(y) * (hi_im - lo_im), VIEW_H);
          nlr = scale_about(pt_re, lo_re, div);
          nhr = scale_about(pt_re, hi_re, div);
          nli = scale_about(pt_im, lo_im, div);
          nhi = scale_about(pt_im, hi_im, div);
          lo_re = nlr;
          hi_re = nhr;
          lo_im = nli;
          hi_im = nhi;
          n_zoom++;
        end
        default: n_spare++;
      endcase
      v.min_re = q48_t'(lo_re);
      v.max_re = q48_t'(hi_re);
      v.min_im = q48_t'(lo_im);
      v.max_im = q48_t'(hi_im);
      expected_views.push_back(v);
    endfunction

    function void check_bounds(view_t got);
      view_t want;
      if (expected_views.size() == 0) begin
        $error("result with no pending event: %0d %0d %0d %0d",
               got.min_re, got.max_re, got.min_im, got.max_im);
        mismatches++;
        return;
      end
      want = expected_views.pop_front();
      n_checked++;
      if (got.min_re !== want.min_re) begin
        $error("out_min_re expected %0d got %0d", want.min_re, got.min_re);
        mismatches++;
      end
      if (got.max_re !== want.max_re) begin
        $error("out_max_re expected %0d got %0d", want.max_re, got.max_re);
        mismatches++;
      end
      if (got.min_im !== want.min_im) begin
        $error("out_min_im expected %0d got %0d", want.min_im, got.min_im);
        mismatches++;
      end
      if (got.max_im !== want.max_im) begin
        $error("out_max_im expected %0d got %0d", want.max_im, got.max_im);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_views.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OPW-1:0]      op = '0;
  logic [PIXW-1:0]     pix_x = '0;
  logic [PIXW-1:0]     pix_y = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  q48_t                out_min_re;
  q48_t                out_max_re;
  q48_t                out_min_im;
  q48_t                out_max_im;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;

  view_tracker tracker;

  complex_viewport_pan_zoom #(
    .VIEW_WIDTH (VIEW_W),
    .VIEW_HEIGHT(VIEW_H)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_min_re(out_min_re),
    .out_max_re(out_max_re),
    .out_min_im(out_min_im),
    .out_max_im(out_max_im)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_bounds({out_min_re, out_max_re, out_min_im, out_max_im});
  end

  task automatic write_home(input reg_idx_t idx, input q48_t v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= {{(PDATA_W-QW){v[QW-1]}}, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.load_home(idx, v);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_event(input logic [OPW-1:0] code, input logic [PIXW-1:0] x,
                            input logic [PIXW-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    op <= code;
    pix_x <= x;
    pix_y <= y;
    do @(posedge clk); while (in_stall);
    tracker.take_event(code, x, y);
  endtask

  // Drop valid and hold until every pending result has been taken
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic q48_t rand_q48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[QW-1:0];
  endfunction

  function automatic logic [PIXW-1:0] rand_pix();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? '1 : '0;
    return PIXW'($urandom_range(1023));
  endfunction

  task automatic write_view(input q48_t a, input q48_t b, input q48_t c, input q48_t d);
    write_home(REG_MIN_RE, a);
    write_home(REG_MAX_RE, b);
    write_home(REG_MIN_IM, c);
    write_home(REG_MAX_IM, d);
  endtask

  task automatic apply_setting(input int k);
    q48_t base_re, base_im;
    base_re = rand_q48() >>> 4;
    base_im = rand_q48() >>> 4;
    case (k)
      0: write_view(HOME_RST[REG_MIN_RE], HOME_RST[REG_MAX_RE],
                    HOME_RST[REG_MIN_IM], HOME_RST[REG_MAX_IM]);
      1: write_view(Q_MIN, Q_MAX, Q_MIN, Q_MAX);
      2: write_view(HOME_RST[REG_MAX_RE], HOME_RST[REG_MIN_RE],
                    HOME_RST[REG_MAX_IM], HOME_RST[REG_MIN_IM]);
      // spans of a few LSBs exercise the rounding of the pan step
      3: write_view(base_re, base_re + q48_t'($urandom_range(40)),
                    base_im, base_im + q48_t'($urandom_range(40)));
      default: write_view(rand_q48(), rand_q48(), rand_q48(), rand_q48());
    endcase
  endtask

  initial begin
    logic [OPW-1:0] code;
    tracker = new;
    tracker.restore_home();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: home view, every op, pointer at the corners and the centre
    send_event(OP_LEFT, 0, 0);
    send_event(OP_RIGHT, 1023, 1023);
    send_event(OP_UP, 0, 1023);
    send_event(OP_DOWN, 1023, 0);
    send_event(OP_ZIN, 0, 0);
    send_event(OP_ZIN, 1023, 1023);
    send_event(OP_ZOUT, 512, 512);
    send_event(OP_ZOUT, 0, 1023);
    send_event(OP_ZIN, 1023, 0);
    send_event(OP_SPARE6, 1023, 1023);
    send_event(OP_SPARE7, 0, 0);
    drain_results();

    // Reversed bounds
    apply_setting(2);
    send_event(OP_LEFT, 0, 0);
    send_event(OP_UP, 0, 0);
    send_event(OP_ZIN, 300, 700);
    send_event(OP_ZOUT, 1023, 1023);
    drain_results();

    // Full-range bounds: pans and corner zoom-ins saturate
    apply_setting(1);
    send_event(OP_RIGHT, 0, 0);
    send_event(OP_DOWN, 0, 0);
    send_event(OP_ZIN, 1023, 1023);
    send_event(OP_ZOUT, 0, 0);
    send_event(OP_ZIN, 0, 1023);
    send_event(OP_SPARE7, 1023, 0);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 66;
        end
        1: begin
          send_idle_pct = 66;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      drain_results();
      apply_setting(p);
      for (int i = 0; i < EVENTS_PER_PHASE; i++) begin
        if (p == 4 && i == 30) hold_requests++;
        if (p == 2 && i == 60) drain_results();
        if ($urandom_range(19) == 0) code = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
        else code = OPW'($urandom_range(OP_ZOUT));
        send_event(code, rand_pix(), rand_pix());
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Covered %0d pans, %0d zooms and %0d unused ops under %0d home-register writes;",
             tracker.n_pan, tracker.n_zoom, tracker.n_spare, tracker.n_writes);
    $display("%0d results compared, %0d field mismatches.", tracker.n_checked,
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
